/* src/tle_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_pkg
// Shared types and constants of the terminal line editor: character codes,
// filter modes, register indexes and the command that runs from the front
// part to the back part.
// ----------------------------------------------------------------------------
package tle_pkg;

   // Character codes
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF_HEX = 8'h66;
   localparam logic [7:0] CH_NUL   = 8'h00;

   // Filter modes
   localparam logic [1:0] MODE_PRINTABLE = 2'd0;
   localparam logic [1:0] MODE_DECIMAL   = 2'd1;
   localparam logic [1:0] MODE_HEX       = 2'd2;

   // Register port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 9;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENFORCE_MODE  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUFFER_LENGTH = 1'd1;
   localparam logic [CSR_DATA_W-1:0]  BUFFER_LENGTH_RESET = 9'd256;

   // Buffer size limit: the least of the line limit and the 8-bit index range
   localparam int MAX_LINE_BYTES = 256;
   localparam int CAP_LIMIT_INT  = (MAX_LINE_BYTES < 256) ? MAX_LINE_BYTES : 256;
   localparam logic [CSR_DATA_W-1:0] CAP_LIMIT = CSR_DATA_W'(CAP_LIMIT_INT);

   // Command queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_CHAR  = 2'd0,
      OP_ENTER = 2'd1,
      OP_ERASE = 2'd2
   } op_type;

   // One command per item that causes results.
   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic [7:0] index;
   } cmd_type;

endpackage

/* src/tle_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_front
// Accepts received bytes, classifies them against the filter mode and the
// room left, keeps the line index and issues one command per item that
// causes results. Also holds the configuration registers.
// ----------------------------------------------------------------------------
module tle_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_rx_byte,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tle_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tle_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            queue_full,
   output logic                            push,
   output tle_pkg::cmd_type                push_cmd
);

   logic [1:0]                      enforce_mode_ff;
   logic [tle_pkg::CSR_DATA_W-1:0]  buffer_length_ff;
   logic [7:0]                      line_index_ff, line_index_in;
   logic [tle_pkg::CSR_DATA_W-1:0]  cap;
   logic                            is_enter, is_erase, passes, room, accept;
   logic                            is_digit;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enforce_mode_ff  <= tle_pkg::MODE_PRINTABLE;
         buffer_length_ff <= tle_pkg::BUFFER_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == tle_pkg::CSR_ENFORCE_MODE) begin
            enforce_mode_ff <= csr_wdata[1:0];
         end else if (csr_index == tle_pkg::CSR_BUFFER_LENGTH) begin
            buffer_length_ff <= csr_wdata;
         end
      end
   end

   // Effective buffer size: clipped to the limit, and never below one slot.
   always_comb begin
      cap = buffer_length_ff;
      if (cap > tle_pkg::CAP_LIMIT) cap = tle_pkg::CAP_LIMIT;
      if (cap == '0) cap = tle_pkg::CSR_DATA_W'(1);
   end

   // Classify the byte.
   always_comb begin
      is_enter = (req_rx_byte == tle_pkg::CH_CR) || (req_rx_byte == tle_pkg::CH_LF);
      is_erase = (req_rx_byte == tle_pkg::CH_BS) || (req_rx_byte == tle_pkg::CH_DEL);
      is_digit = (req_rx_byte >= tle_pkg::CH_ZERO) && (req_rx_byte <= tle_pkg::CH_NINE);
      unique case (enforce_mode_ff)
         tle_pkg::MODE_PRINTABLE: begin
            passes = (req_rx_byte >= tle_pkg::CH_SPACE) && (req_rx_byte <= tle_pkg::CH_TILDE);
         end
         tle_pkg::MODE_DECIMAL: begin
            passes = is_digit;
         end
         tle_pkg::MODE_HEX: begin
            passes = is_digit
                  || ((req_rx_byte >= tle_pkg::CH_LA) && (req_rx_byte <= tle_pkg::CH_LF_HEX))
                  || ((req_rx_byte >= tle_pkg::CH_UA) && (req_rx_byte <= tle_pkg::CH_UF));
         end
         default: begin
            passes = 1'b0;
         end
      endcase
      // One slot is kept for the terminator.
      room = {1'b0, line_index_ff} < (cap - tle_pkg::CSR_DATA_W'(1));
   end

   // Build the command and the next line index.
   always_comb begin
      push          = 1'b0;
      line_index_in = line_index_ff;
      push_cmd.op    = tle_pkg::OP_CHAR;
      push_cmd.data  = req_rx_byte;
      push_cmd.index = line_index_ff;
      if (is_enter) begin
         push_cmd.op   = tle_pkg::OP_ENTER;
         push          = accept;
         line_index_in = accept ? 8'd0 : line_index_ff;
      end else if (is_erase) begin
         push_cmd.op    = tle_pkg::OP_ERASE;
         push_cmd.index = line_index_ff - 8'd1;
         if (line_index_ff != 8'd0) begin
            push          = accept;
            line_index_in = accept ? (line_index_ff - 8'd1) : line_index_ff;
         end
      end else if (passes && room) begin
         push          = accept;
         line_index_in = accept ? (line_index_ff + 8'd1) : line_index_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_index_ff <= 8'd0;
      end else begin
         line_index_ff <= line_index_in;
      end
   end

endmodule

/* src/tle_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_fifo
// Short command queue between the front and the back part, so that each
// side can stall on its own.
// ----------------------------------------------------------------------------
module tle_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tle_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             nonempty,
   output tle_pkg::cmd_type head_cmd
);

   tle_pkg::cmd_type                 slot_ff [tle_pkg::QUEUE_DEPTH];
   logic [tle_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [tle_pkg::QUEUE_CNT_W-1:0]  count_ff, count_in;

   assign full     = (count_ff == tle_pkg::QUEUE_CNT_W'(tle_pkg::QUEUE_DEPTH));
   assign nonempty = (count_ff != '0);
   assign head_cmd = slot_ff[rd_ptr_ff];

   // Occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + tle_pkg::QUEUE_CNT_W'(1);
      if (pop && !push) count_in = count_ff - tle_pkg::QUEUE_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + tle_pkg::QUEUE_PTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + tle_pkg::QUEUE_PTR_W'(1);
         count_ff <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* src/tle_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_back
// Carries out the command at the head of the queue, one result per cycle
// while rsp_stall allows it, into a registered result stage.
// ----------------------------------------------------------------------------
module tle_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             nonempty,
   input  tle_pkg::cmd_type head_cmd,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_tx_valid,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_store_valid,
   output logic [7:0]       rsp_store_index,
   output logic [7:0]       rsp_store_data,
   output logic             rsp_line_done,
   output logic [7:0]       rsp_line_length,
   output logic             rsp_last_of_run
);

   logic       rsp_valid_ff;
   logic [1:0] step_ff, step_in;
   logic       load;
   logic [7:0] tx_in, store_index_in, store_data_in, length_in;
   logic       store_in, done_in, last_in;
   logic [7:0] tx_ff, store_index_ff, store_data_ff, length_ff;
   logic       store_ff, done_ff, last_ff;

   assign load = nonempty && (!rsp_valid_ff || !rsp_stall);
   assign pop  = load && last_in;

   // Result of the current step of the head command
   always_comb begin
      tx_in          = head_cmd.data;
      store_in       = 1'b0;
      store_index_in = 8'd0;
      store_data_in  = 8'd0;
      done_in        = 1'b0;
      length_in      = 8'd0;
      last_in        = 1'b0;
      unique case (head_cmd.op)
         tle_pkg::OP_ENTER: begin
            if (step_ff == 2'd0) begin
               tx_in          = tle_pkg::CH_CR;
               store_in       = 1'b1;
               store_index_in = head_cmd.index;
               store_data_in  = tle_pkg::CH_NUL;
            end else begin
               tx_in     = tle_pkg::CH_LF;
               done_in   = 1'b1;
               length_in = head_cmd.index;
               last_in   = 1'b1;
            end
         end
         tle_pkg::OP_ERASE: begin
            if (step_ff == 2'd0) begin
               tx_in          = tle_pkg::CH_BS;
               store_in       = 1'b1;
               store_index_in = head_cmd.index;
               store_data_in  = tle_pkg::CH_NUL;
            end else if (step_ff == 2'd1) begin
               tx_in = tle_pkg::CH_SPACE;
            end else begin
               tx_in   = tle_pkg::CH_BS;
               last_in = 1'b1;
            end
         end
         default: begin
            // Ordinary character: echo and store in one result.
            store_in       = 1'b1;
            store_index_in = head_cmd.index;
            store_data_in  = head_cmd.data;
            last_in        = 1'b1;
         end
      endcase
      step_in = step_ff;
      if (load) step_in = last_in ? 2'd0 : (step_ff + 2'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= 2'd0;
      end else begin
         step_ff <= step_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (load) begin
         tx_ff          <= tx_in;
         store_ff       <= store_in;
         store_index_ff <= store_index_in;
         store_data_ff  <= store_data_in;
         done_ff        <= done_in;
         length_ff      <= length_in;
         last_ff        <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tx_valid    = 1'b1;
   assign rsp_tx_byte     = tx_ff;
   assign rsp_store_valid = store_ff;
   assign rsp_store_index = store_index_ff;
   assign rsp_store_data  = store_data_ff;
   assign rsp_line_done   = done_ff;
   assign rsp_line_length = length_ff;
   assign rsp_last_of_run = last_ff;

endmodule

/* src/terminal_line_editor_with_echo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_line_editor_with_echo
// Canonical-mode line editor: turns received terminal bytes into line buffer
// writes and echo bytes.
// ----------------------------------------------------------------------------
// A received byte is accepted and queued as a command whenever the
// four-entry command queue has room; bytes that cause no result (rejected,
// line full, backspace at the start) leave nothing behind. The result side
// gives one result per cycle while rsp_stall is low and a command waits: one
// for a stored character, two for enter, three for backspace. Sustained rate
// is set by that result stage. Each run of results ends with last_of_run set.
// The line buffer itself lies outside. The user must write enforce_mode and
// buffer_length via the csr port only while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module terminal_line_editor_with_echo (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_tx_valid,
   output logic [7:0]                      rsp_tx_byte,
   output logic                            rsp_store_valid,
   output logic [7:0]                      rsp_store_index,
   output logic [7:0]                      rsp_store_data,
   output logic                            rsp_line_done,
   output logic [7:0]                      rsp_line_length,
   output logic                            rsp_last_of_run,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tle_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tle_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic             push, pop, queue_full, nonempty;
   tle_pkg::cmd_type push_cmd, head_cmd;

   // Front part: classification, line index and registers
   tle_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .queue_full  (queue_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // Command queue
   tle_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .nonempty (nonempty),
      .head_cmd (head_cmd)
   );

   // Back part: result generation
   tle_back u_back (
      .clock           (clock),
      .reset           (reset),
      .nonempty        (nonempty),
      .head_cmd        (head_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tx_valid    (rsp_tx_valid),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_store_valid (rsp_store_valid),
      .rsp_store_index (rsp_store_index),
      .rsp_store_data  (rsp_store_data),
      .rsp_line_done   (rsp_line_done),
      .rsp_line_length (rsp_line_length),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // A finished line always closes its run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_done |-> rsp_last_of_run)
      else $error("line_done on a result that is not the last of its run");

   // A character write is a run of one result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_store_valid && (rsp_store_data != tle_pkg::CH_NUL)
      |-> rsp_last_of_run)
      else $error("character write inside a longer run");

   // The results of one item follow without gaps.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run |=> rsp_valid)
      else $error("gap inside a run of results");

endmodule
